// ----- hw/rtl/etfs_pkg.sv -----
// Shared types, codes and constants for the ECU temperature fault supervisor.
`timescale 1ns / 1ps
`default_nettype none

package etfs_pkg;

    // Field widths
    localparam int unsigned ACTION_W  = 3;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned TEMP_W    = 6;
    localparam int unsigned VOLT_W    = 27;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned RUN_W     = 3;
    localparam int unsigned STATE_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // Default qualification run length
    localparam int unsigned QUALIFY_RUN_DEF = 6;

    // Message words below this are temperature readings
    localparam logic [WORD_W-1:0] TEMP_MSG_LIMIT = 32'd33;

    // Voltage word divisor is 40 = 8 * 5: shift by three, then multiply by
    // ceil(2^32 / 5) and keep the upper bits (exact for a 29-bit dividend).
    localparam int unsigned VOLT_SHIFT  = 3;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned DIVIDEND_W  = WORD_W - VOLT_SHIFT;
    localparam int unsigned RECIP_W     = 30;
    localparam logic [RECIP_W-1:0] RECIP_5 = 30'd858993460;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Event codes
    localparam logic [ACTION_W-1:0] ACT_MESSAGE   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_KEEPALIVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_EVALUATE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STATUS    = 3'd4;

    // Reported state codes
    localparam logic [STATE_W-1:0] ST_FAULT     = 2'd0;
    localparam logic [STATE_W-1:0] ST_COMM_LOST = 2'd1;
    localparam logic [STATE_W-1:0] ST_HEAT      = 2'd2;
    localparam logic [STATE_W-1:0] ST_NORMAL    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 3'd5;

    // Configuration reset values
    localparam logic [TEMP_W-1:0]  TEMP_LOW_RST     = 6'd10;
    localparam logic [TEMP_W-1:0]  TEMP_HIGH_RST    = 6'd30;
    localparam logic [VOLT_W-1:0]  VOLT_LOW_RST     = 27'd0;
    localparam logic [VOLT_W-1:0]  VOLT_HIGH_RST    = 27'd107374182;
    localparam logic [WORD_W-1:0]  ACK_CODE_RST     = 32'd94;
    localparam logic [COUNT_W-1:0] REPEAT_LIMIT_RST = 8'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [WORD_W-1:0]   message_word;
    } t_in_item;

    typedef struct packed {
        logic [STATE_W-1:0] system_state;
        logic [TEMP_W-1:0]  reported_temp;
        logic               send_keepalive;
        logic               request_voltage;
        logic               link_ok;
        logic               alarm_comm;
        logic               alarm_fault;
        logic               alarm_heat;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/etfs_div40.sv -----
// Constant divide-by-40 of a received voltage word by reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module etfs_div40
    import etfs_pkg::*;
(
    input  wire logic [WORD_W-1:0] i_word,
    output logic      [VOLT_W-1:0] o_quot
);

    localparam int unsigned PROD_W = DIVIDEND_W + RECIP_W;

    logic [DIVIDEND_W-1:0] w_div8;
    logic [PROD_W-1:0]     w_prod;

    // word / 40 = (word >> 3) / 5
    assign w_div8 = i_word[WORD_W-1:VOLT_SHIFT];
    assign w_prod = PROD_W'(w_div8) * PROD_W'(RECIP_5);
    assign o_quot = w_prod[RECIP_SHIFT +: VOLT_W];

endmodule

`default_nettype wire

// ----- hw/rtl/ecu_temperature_fault_supervisor_unit.sv -----
// Top level of the ECU temperature fault supervisor: state, config and result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one event per transaction and returns exactly one status result for it.
// The whole update is combinational between the accepted event and the result
// register, so an event can be taken every clock unless the input stalls; the
// result appears in the cycle after acceptance. The input side stalls only while a
// result is held in the output register and the output side is stalled.
// Configuration writes are always ready and should be issued while idle.

module ecu_temperature_fault_supervisor_unit
    import etfs_pkg::*;
#(
    parameter int unsigned QUALIFY_RUN = QUALIFY_RUN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // event channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [TEMP_W-1:0]  r_temp_low;
    logic [TEMP_W-1:0]  r_temp_high;
    logic [VOLT_W-1:0]  r_volt_low;
    logic [VOLT_W-1:0]  r_volt_high;
    logic [WORD_W-1:0]  r_ack_code;
    logic [COUNT_W-1:0] r_repeat_limit;

    // Supervisor state
    logic               r_heat_flag,  n_heat_flag;
    logic               r_fault_flag, n_fault_flag;
    logic               r_ack_pending, n_ack_pending;
    logic               r_link_lost,  n_link_lost;
    logic               r_temp_ready, n_temp_ready;
    logic [TEMP_W-1:0]  r_pending_temp, n_pending_temp;
    logic [VOLT_W-1:0]  r_stored_voltage, n_stored_voltage;
    logic [RUN_W-1:0]   r_run, n_run;
    logic [COUNT_W-1:0] r_fault_count, n_fault_count;
    logic [COUNT_W-1:0] r_heat_count, n_heat_count;
    logic [COUNT_W-1:0] r_lost_count, n_lost_count;
    logic [STATE_W-1:0] r_state_code, n_state_code;
    logic [TEMP_W-1:0]  r_report_temp, n_report_temp;

    // Result register
    logic               r_out_valid;
    t_out_item          r_out_data, n_out_data;

    logic               w_in_accept;
    logic               w_cfg_write;
    logic [VOLT_W-1:0]  w_volt_quot;
    logic [RUN_W-1:0]   w_run_inc;
    logic               w_in_range;
    logic               w_volt_ok;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    etfs_div40 u_div40 (
        .i_word (i_in_data.message_word),
        .o_quot (w_volt_quot)
    );

    // Qualification helpers
    assign w_run_inc  = r_run + RUN_W'(1);
    assign w_in_range = (r_pending_temp >= r_temp_low) && (r_pending_temp <= r_temp_high);
    assign w_volt_ok  = (r_volt_low <= r_stored_voltage) && (r_stored_voltage <= r_volt_high);

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

    // Next state and result for one event
    always_comb begin
        n_heat_flag      = r_heat_flag;
        n_fault_flag     = r_fault_flag;
        n_ack_pending    = r_ack_pending;
        n_link_lost      = r_link_lost;
        n_temp_ready     = r_temp_ready;
        n_pending_temp   = r_pending_temp;
        n_stored_voltage = r_stored_voltage;
        n_run            = r_run;
        n_fault_count    = r_fault_count;
        n_heat_count     = r_heat_count;
        n_lost_count     = r_lost_count;
        n_state_code     = r_state_code;
        n_report_temp    = r_report_temp;
        n_out_data       = '0;

        case (i_in_data.action)
            ACT_MESSAGE: begin
                if (i_in_data.message_word == r_ack_code) begin
                    n_link_lost   = 1'b0;
                    n_ack_pending = 1'b0;
                end else if (i_in_data.message_word < TEMP_MSG_LIMIT) begin
                    n_pending_temp = i_in_data.message_word[TEMP_W-1:0];
                    n_temp_ready   = 1'b1;
                    n_link_lost    = 1'b0;
                    n_ack_pending  = 1'b0;
                end else begin
                    n_stored_voltage = w_volt_quot;
                end
            end
            ACT_KEEPALIVE: begin
                n_ack_pending             = 1'b1;
                n_out_data.send_keepalive = 1'b1;
            end
            ACT_CHECK: begin
                n_link_lost = r_ack_pending;
            end
            ACT_EVALUATE: begin
                if (r_temp_ready) begin
                    n_temp_ready = 1'b0;
                    if (w_in_range) begin
                        // in range: run restarts, no trip
                        n_run       = '0;
                        n_heat_flag = 1'b0;
                        if (r_fault_count != '0) begin
                            n_fault_count = sat_inc(r_fault_count);
                        end else begin
                            n_report_temp = r_pending_temp;
                        end
                    end else if (w_run_inc >= RUN_W'(QUALIFY_RUN) || r_heat_flag) begin
                        // alarm trips; stored voltage picks overheat or fault
                        n_run                      = '0;
                        n_out_data.request_voltage = 1'b1;
                        n_report_temp              = r_pending_temp;
                        if (w_volt_ok) begin
                            n_state_code  = ST_HEAT;
                            n_fault_count = '0;
                            n_heat_count  = sat_inc(r_heat_count);
                            n_fault_flag  = 1'b0;
                            n_heat_flag   = 1'b1;
                        end else begin
                            n_state_code  = ST_FAULT;
                            n_fault_count = sat_inc(r_fault_count);
                            n_heat_count  = '0;
                            n_heat_flag   = 1'b0;
                            n_fault_flag  = 1'b1;
                        end
                    end else begin
                        n_run = w_run_inc;
                        if (r_fault_count != '0) begin
                            n_fault_count = sat_inc(r_fault_count);
                        end else begin
                            n_report_temp = r_pending_temp;
                        end
                    end
                end
            end
            ACT_STATUS: begin
                if (!r_heat_flag && !r_fault_flag && !r_link_lost) begin
                    n_state_code = ST_NORMAL;
                    n_lost_count = '0;
                end else if (r_ack_pending && r_link_lost) begin
                    n_state_code = ST_COMM_LOST;
                    n_lost_count = sat_inc(r_lost_count);
                end
            end
            default: begin
            end
        endcase

        // snapshot of the report after the update
        n_out_data.system_state  = n_state_code;
        n_out_data.reported_temp = n_report_temp;
        n_out_data.link_ok       = !n_link_lost;
        n_out_data.alarm_comm    = (n_lost_count >= r_repeat_limit);
        n_out_data.alarm_fault   = (n_fault_count >= r_repeat_limit);
        n_out_data.alarm_heat    = (n_heat_count >= r_repeat_limit);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_low     <= TEMP_LOW_RST;
            r_temp_high    <= TEMP_HIGH_RST;
            r_volt_low     <= VOLT_LOW_RST;
            r_volt_high    <= VOLT_HIGH_RST;
            r_ack_code     <= ACK_CODE_RST;
            r_repeat_limit <= REPEAT_LIMIT_RST;
        end else if (w_cfg_write) begin
            case (i_cfg_index)
                CFG_TEMP_LOW:     r_temp_low     <= i_cfg_data[TEMP_W-1:0];
                CFG_TEMP_HIGH:    r_temp_high    <= i_cfg_data[TEMP_W-1:0];
                CFG_VOLT_LOW:     r_volt_low     <= i_cfg_data[VOLT_W-1:0];
                CFG_VOLT_HIGH:    r_volt_high    <= i_cfg_data[VOLT_W-1:0];
                CFG_ACK_CODE:     r_ack_code     <= i_cfg_data;
                CFG_REPEAT_LIMIT: r_repeat_limit <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Supervisor state, updated on each accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_flag      <= 1'b0;
            r_fault_flag     <= 1'b0;
            r_ack_pending    <= 1'b0;
            r_link_lost      <= 1'b0;
            r_temp_ready     <= 1'b0;
            r_pending_temp   <= '0;
            r_stored_voltage <= '0;
            r_run            <= '0;
            r_fault_count    <= '0;
            r_heat_count     <= '0;
            r_lost_count     <= '0;
            r_state_code     <= ST_NORMAL;
            r_report_temp    <= '0;
        end else if (w_in_accept) begin
            r_heat_flag      <= n_heat_flag;
            r_fault_flag     <= n_fault_flag;
            r_ack_pending    <= n_ack_pending;
            r_link_lost      <= n_link_lost;
            r_temp_ready     <= n_temp_ready;
            r_pending_temp   <= n_pending_temp;
            r_stored_voltage <= n_stored_voltage;
            r_run            <= n_run;
            r_fault_count    <= n_fault_count;
            r_heat_count     <= n_heat_count;
            r_lost_count     <= n_lost_count;
            r_state_code     <= n_state_code;
            r_report_temp    <= n_report_temp;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/ecu_temperature_fault_supervisor_unit_tb.sv -----
// Self-checking testbench for the ECU temperature fault supervisor top level.
`timescale 1ns / 1ps

module ecu_temperature_fault_supervisor_unit_tb;
    import etfs_pkg::*;

    localparam int unsigned VOLT_DIVISOR = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned MAX_PRINT    = 60;
    localparam int unsigned PHASE_ITEMS  = 155;
    localparam int unsigned HOLD_CYCLES  = 120;

    // Highest action code, one the block must ignore
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_data   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_data  = '0;

    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    ecu_temperature_fault_supervisor_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow configuration
    logic [TEMP_W-1:0]  c_temp_lo = TEMP_LOW_RST;
    logic [TEMP_W-1:0]  c_temp_hi = TEMP_HIGH_RST;
    logic [VOLT_W-1:0]  c_volt_lo = VOLT_LOW_RST;
    logic [VOLT_W-1:0]  c_volt_hi = VOLT_HIGH_RST;
    logic [WORD_W-1:0]  c_ack     = ACK_CODE_RST;
    logic [COUNT_W-1:0] c_limit   = REPEAT_LIMIT_RST;

    // Shadow supervisor state
    logic               p_heat       = 1'b0;
    logic               p_fault      = 1'b0;
    logic               p_ack_wait   = 1'b0;
    logic               p_link_down  = 1'b0;
    logic               p_temp_valid = 1'b0;
    logic [TEMP_W-1:0]  p_temp       = '0;
    logic [VOLT_W-1:0]  p_volt       = '0;
    logic [RUN_W-1:0]   p_run        = '0;
    logic [COUNT_W-1:0] p_fault_cnt  = '0;
    logic [COUNT_W-1:0] p_heat_cnt   = '0;
    logic [COUNT_W-1:0] p_lost_cnt   = '0;
    logic [STATE_W-1:0] p_state      = ST_NORMAL;
    logic [TEMP_W-1:0]  p_report     = '0;

    t_out_item status_expected[$];
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned hold_request = 0;
    bit          steady       = 1'b0;

    typedef struct {
        t_in_item  ev;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    t_dir_row directed_rows[$];

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Saturating event counter
    function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // Advance the shadow supervisor by one event and return its status report
    function automatic t_out_item supervise_step(t_in_item ev);
        t_out_item         r;
        logic              keepalive;
        logic              req_volt;
        logic              trip;
        logic [TEMP_W-1:0] t;
        logic [WORD_W-1:0] quot;
        keepalive = 1'b0;
        req_volt  = 1'b0;
        trip      = 1'b0;
        case (ev.action)
            ACT_MESSAGE: begin
                if (ev.message_word == c_ack) begin
                    p_link_down = 1'b0;
                    p_ack_wait  = 1'b0;
                end else if (ev.message_word < TEMP_MSG_LIMIT) begin
                    p_temp       = ev.message_word[TEMP_W-1:0];
                    p_temp_valid = 1'b1;
                    p_link_down  = 1'b0;
                    p_ack_wait   = 1'b0;
                end else begin
                    quot   = ev.message_word / VOLT_DIVISOR;
                    p_volt = quot[VOLT_W-1:0];
                end
            end
            ACT_KEEPALIVE: begin
                p_ack_wait = 1'b1;
                keepalive  = 1'b1;
            end
            ACT_CHECK: p_link_down = p_ack_wait;
            ACT_EVALUATE: begin
                if (p_temp_valid) begin
                    t            = p_temp;
                    p_temp_valid = 1'b0;
                    // qualification run; an active overheat trips at once
                    if (t >= c_temp_lo && t <= c_temp_hi) begin
                        p_run  = '0;
                        p_heat = 1'b0;
                    end else begin
                        p_run = p_run + 1'b1;
                        if (p_run >= QUALIFY_RUN_DEF || p_heat) begin
                            p_heat = 1'b1;
                            p_run  = '0;
                            trip   = 1'b1;
                        end
                    end
                    if (trip) begin
                        req_volt = 1'b1;
                        if (c_volt_lo <= p_volt && p_volt <= c_volt_hi) begin
                            p_state     = ST_HEAT;
                            p_fault_cnt = '0;
                            p_heat_cnt  = bump(p_heat_cnt);
                            p_fault     = 1'b0;
                            p_heat      = 1'b1;
                        end else begin
                            p_fault_cnt = bump(p_fault_cnt);
                            p_heat_cnt  = '0;
                            p_heat      = 1'b0;
                            p_fault     = 1'b1;
                            p_state     = ST_FAULT;
                        end
                        p_report = t;
                    end else if (p_fault_cnt != 0) begin
                        p_fault_cnt = bump(p_fault_cnt);
                    end else begin
                        p_report = t;
                    end
                end
            end
            ACT_STATUS: begin
                if (!p_heat && !p_fault && !p_link_down) begin
                    p_state    = ST_NORMAL;
                    p_lost_cnt = '0;
                end else if (p_ack_wait && p_link_down) begin
                    p_state    = ST_COMM_LOST;
                    p_lost_cnt = bump(p_lost_cnt);
                end
            end
            default: ;
        endcase
        r.system_state    = p_state;
        r.reported_temp   = p_report;
        r.send_keepalive  = keepalive;
        r.request_voltage = req_volt;
        r.link_ok         = !p_link_down;
        r.alarm_comm      = (p_lost_cnt >= c_limit);
        r.alarm_fault     = (p_fault_cnt >= c_limit);
        r.alarm_heat      = (p_heat_cnt >= c_limit);
        return r;
    endfunction

    // Hand-written status report for the directed rows
    function automatic t_out_item report_of(logic [STATE_W-1:0] st, logic [TEMP_W-1:0] temp,
                                            bit ka, bit rv, bit ok, bit ac, bit af, bit ah);
        t_out_item r;
        r.system_state    = st;
        r.reported_temp   = temp;
        r.send_keepalive  = ka;
        r.request_voltage = rv;
        r.link_ok         = ok;
        r.alarm_comm      = ac;
        r.alarm_fault     = af;
        r.alarm_heat      = ah;
        return r;
    endfunction

    function automatic void row(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] word,
                                bit typed = 1'b0, t_out_item want = '0);
        t_dir_row d;
        d.ev.action       = act;
        d.ev.message_word = word;
        d.typed           = typed;
        d.want            = want;
        directed_rows.push_back(d);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < MAX_PRINT)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // Offer one event transaction; predict its status once it is taken
    task automatic offer(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] word,
                         bit typed = 1'b0, t_out_item want = '0);
        t_in_item  ev;
        t_out_item predicted;
        ev.action       = act;
        ev.message_word = word;
        while (!steady && $urandom_range(0, 99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        predicted = supervise_step(ev);
        status_expected.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Wait until every status has come back and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (status_expected.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TEMP_LOW:     c_temp_lo = val[TEMP_W-1:0];
            CFG_TEMP_HIGH:    c_temp_hi = val[TEMP_W-1:0];
            CFG_VOLT_LOW:     c_volt_lo = val[VOLT_W-1:0];
            CFG_VOLT_HIGH:    c_volt_hi = val[VOLT_W-1:0];
            CFG_ACK_CODE:     c_ack     = val;
            CFG_REPEAT_LIMIT: c_limit   = val[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_config(logic [TEMP_W-1:0] lo, logic [TEMP_W-1:0] hi,
                               logic [VOLT_W-1:0] vlo, logic [VOLT_W-1:0] vhi,
                               logic [WORD_W-1:0] ack, logic [COUNT_W-1:0] lim);
        write_reg(CFG_TEMP_LOW, WORD_W'(lo));
        write_reg(CFG_TEMP_HIGH, WORD_W'(hi));
        write_reg(CFG_VOLT_LOW, WORD_W'(vlo));
        write_reg(CFG_VOLT_HIGH, WORD_W'(vhi));
        write_reg(CFG_ACK_CODE, ack);
        write_reg(CFG_REPEAT_LIMIT, WORD_W'(lim));
    endtask

    // Temperature readings biased to the edges of the normal band
    function automatic logic [WORD_W-1:0] pick_temp();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 32);
            1: return (c_temp_lo > 0) ? c_temp_lo - 1 : 32;
            2: return (c_temp_hi < 32) ? c_temp_hi + 1 : 0;
            default: return $urandom_range(0, 1) ? 32 : 0;
        endcase
    endfunction

    // Voltage words, half of them landing inside the overheat band
    function automatic logic [WORD_W-1:0] pick_voltage();
        logic [63:0]       w;
        logic [VOLT_W-1:0] v;
        if ($urandom_range(0, 1)) begin
            v = VOLT_W'($urandom_range(c_volt_lo, c_volt_hi));
            w = 64'(v) * VOLT_DIVISOR + $urandom_range(0, VOLT_DIVISOR - 1);
            if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
            return w[WORD_W-1:0];
        end
        return $urandom;
    endfunction

    // Random traffic made mostly of well-formed event sequences
    task automatic run_traffic(int unsigned n_items, bit squeeze);
        int unsigned target;
        int unsigned pick;
        bit          squeezed;
        target   = items_sent + n_items;
        squeezed = 1'b0;
        while (items_sent < target) begin
            if (squeeze && !squeezed && items_sent + (2 * n_items) / 3 >= target) begin
                hold_request = HOLD_CYCLES;
                squeezed     = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                offer(ACT_MESSAGE, pick_temp());
                offer(ACT_EVALUATE, $urandom);
            end else if (pick < 55) begin
                offer(ACT_MESSAGE, pick_voltage());
            end else if (pick < 70) begin
                offer(ACT_KEEPALIVE, $urandom);
                if ($urandom_range(0, 1)) offer(ACT_MESSAGE, c_ack);
                offer(ACT_CHECK, $urandom);
                offer(ACT_STATUS, $urandom);
            end else if (pick < 80) begin
                offer(ACT_MESSAGE, c_ack);
            end else if (pick < 90) begin
                offer(ACT_STATUS, $urandom);
            end else begin
                offer(ACTION_W'($urandom_range(ACT_MESSAGE, ACT_UNUSED_HI)), $urandom);
            end
        end
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= !steady && ($urandom_range(0, 99) < 34);
            end
        end
    end

    // Compare each status transaction with the oldest prediction
    always @(posedge clk) begin : status_check
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (status_expected.size() == 0) begin
                report_mismatch("status with nothing pending", 32'(o_out_data), 'x);
            end else begin
                want = status_expected.pop_front();
                check_field("system_state", 32'(o_out_data.system_state),
                            32'(want.system_state));
                check_field("reported_temp", 32'(o_out_data.reported_temp),
                            32'(want.reported_temp));
                check_field("send_keepalive", 32'(o_out_data.send_keepalive),
                            32'(want.send_keepalive));
                check_field("request_voltage", 32'(o_out_data.request_voltage),
                            32'(want.request_voltage));
                check_field("link_ok", 32'(o_out_data.link_ok), 32'(want.link_ok));
                check_field("alarm_comm", 32'(o_out_data.alarm_comm),
                            32'(want.alarm_comm));
                check_field("alarm_fault", 32'(o_out_data.alarm_fault),
                            32'(want.alarm_fault));
                check_field("alarm_heat", 32'(o_out_data.alarm_heat),
                            32'(want.alarm_heat));
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main_flow
        logic [TEMP_W-1:0] lo;
        logic [TEMP_W-1:0] hi;
        logic [VOLT_W-1:0] va;
        logic [VOLT_W-1:0] vb;
        logic [WORD_W-1:0] ack;

        // Directed: link loss, ignored codes, message classes, overheat run
        row(ACT_STATUS, 32'h0, 1'b1, report_of(ST_NORMAL, 6'd0, 0, 0, 1, 0, 0, 0));
        row(ACT_EVALUATE, 32'hFFFF_FFFF, 1'b1,
            report_of(ST_NORMAL, 6'd0, 0, 0, 1, 0, 0, 0));
        row(ACT_KEEPALIVE, 32'h0, 1'b1, report_of(ST_NORMAL, 6'd0, 1, 0, 1, 0, 0, 0));
        row(ACT_CHECK, 32'h0, 1'b1, report_of(ST_NORMAL, 6'd0, 0, 0, 0, 0, 0, 0));
        row(ACT_STATUS, 32'h0, 1'b1, report_of(ST_COMM_LOST, 6'd0, 0, 0, 0, 0, 0, 0));
        row(ACT_UNUSED_HI, 32'hFFFF_FFFF, 1'b1,
            report_of(ST_COMM_LOST, 6'd0, 0, 0, 0, 0, 0, 0));
        row(ACT_MESSAGE, ACK_CODE_RST, 1'b1,
            report_of(ST_COMM_LOST, 6'd0, 0, 0, 1, 0, 0, 0));
        row(ACT_MESSAGE, 32'hFFFF_FFFF, 1'b1,
            report_of(ST_COMM_LOST, 6'd0, 0, 0, 1, 0, 0, 0));
        row(ACT_MESSAGE, 32'd33, 1'b1, report_of(ST_COMM_LOST, 6'd0, 0, 0, 1, 0, 0, 0));
        row(ACT_MESSAGE, 32'd32, 1'b1, report_of(ST_COMM_LOST, 6'd0, 0, 0, 1, 0, 0, 0));
        row(ACT_EVALUATE, 32'h0, 1'b1, report_of(ST_COMM_LOST, 6'd32, 0, 0, 1, 0, 0, 0));
        row(ACT_MESSAGE, 32'd0);
        row(ACT_EVALUATE, 32'h0);
        row(ACT_MESSAGE, 32'd9);
        row(ACT_EVALUATE, 32'h0);
        row(ACT_MESSAGE, 32'd31);
        row(ACT_EVALUATE, 32'h0);
        row(ACT_MESSAGE, 32'd1);
        row(ACT_EVALUATE, 32'h0);
        row(ACT_MESSAGE, 32'd31);
        row(ACT_EVALUATE, 32'h0);
        row(ACT_MESSAGE, 32'd5);
        row(ACT_EVALUATE, 32'h0);
        row(ACT_MESSAGE, 32'd31);
        row(ACT_EVALUATE, 32'h0);
        row(ACT_MESSAGE, 32'd10);
        row(ACT_EVALUATE, 32'h0);
        row(ACT_STATUS, 32'h0);

        // Hold reset, then release it
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].ev.action, directed_rows[i].ev.message_word,
                  directed_rows[i].typed, directed_rows[i].want);

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: load_config(6'd0, 6'd32, 27'd0, VOLT_HIGH_RST, 32'd0, 8'd1);
                1: load_config(6'd32, 6'd0, VOLT_HIGH_RST, VOLT_HIGH_RST, 32'hFFFF_FFFF,
                               8'd255);
                2: load_config(6'd12, 6'd20, 27'd1000000, 27'd50000000, 32'd7, 8'd0);
                3, 4: begin
                    lo  = TEMP_W'($urandom_range(0, 32));
                    hi  = TEMP_W'($urandom_range(0, 32));
                    va  = VOLT_W'($urandom_range(0, VOLT_HIGH_RST));
                    vb  = VOLT_W'($urandom_range(va, VOLT_HIGH_RST));
                    ack = $urandom_range(0, 1) ? 32'($urandom_range(0, 32)) : 32'($urandom);
                    load_config(lo, hi, va, vb, ack, 8'($urandom_range(1, 6)));
                end
                default: load_config(TEMP_LOW_RST, TEMP_HIGH_RST, VOLT_LOW_RST,
                                     VOLT_HIGH_RST, ACK_CODE_RST, REPEAT_LIMIT_RST);
            endcase
            steady = (ph == 4);
            run_traffic(PHASE_ITEMS, ph == 2);
        end

        settle();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
